@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/mbe_pkg.sv @@
// Types and constants of the Mandelbrot escape-time block.
package mbe_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 32;
    localparam int ITER_W   = 16;
    localparam int BRIGHT_W = 8;

    // Width of one operand slice of the shared multiplier.
    localparam int LIMB_W = 32;

    // Register reset value and brightness ceiling.
    localparam logic [ITER_W-1:0]   MAX_ITER_RESET = 16'd5000;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX     = 8'd255;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_XY,
        S_UPDATE,
        S_MAGN,
        S_MUL_XX,
        S_MUL_YY,
        S_TEST,
        S_DONE
    } state_t;

endpackage

@@ design/mbe_if.sv @@
// Handshake channels of the Mandelbrot escape-time block.

// Point channel: one complex point c per item.
interface mbe_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mbe_pkg::COORD_W-1:0]  c_real;
    logic signed [mbe_pkg::COORD_W-1:0]  c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// Result channel: membership flag and brightness per item.
interface mbe_out_if;
    logic                                valid;
    logic                                ready;
    logic                                in_set;
    logic [mbe_pkg::BRIGHT_W-1:0]        brightness;

    modport source (output valid, output in_set, output brightness, input ready);
    modport sink   (input valid, input in_set, input brightness, output ready);
endinterface

// Configuration channel: writes the iteration limit.
interface mbe_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mbe_pkg::ITER_W-1:0]          max_iterations;

    modport source (output valid, output max_iterations, input ready);
    modport sink   (input valid, input max_iterations, output ready);
endinterface

@@ design/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time engine: iterates z = z*z + c for one point at a time.
//
// Each point iterates z = z*z + c from z = 0 until |z|^2 > 4 or max_iterations
// iterations have run, then returns in_set and a brightness count saturated at
// 255. All arithmetic is exact two's complement fixed point with FRAC_BITS
// fraction bits. One 32x32 multiplier is shared by the three products of an
// iteration (x*y, x*x, y*y), each taken in NL*NL slices whose registered
// products are accumulated, where NL = ceil((max(FRAC_BITS+3, 32)) / 32);
// separate states form the new z (UPDATE), its magnitudes (MAGN) and the
// escape test (TEST). The block takes no new point while one is in progress;
// a finished result waits in the output register, and the next point is
// accepted meanwhile.
`include "assert_macros.svh"

module mandelbrot_escape_time #(
    parameter int FRAC_BITS   = 28,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mbe_in_if.sink     point,
    mbe_out_if.source  result,
    mbe_cfg_if.sink    cfg
);

    // Widths: z parts, their magnitudes, slices and exact squares.
    localparam int ZW    = (FRAC_BITS + 4 > 33) ? FRAC_BITS + 4 : 33;
    localparam int MW    = ZW - 1;
    localparam int LW    = mbe_pkg::LIMB_W;
    localparam int NL    = (MW + LW - 1) / LW;
    localparam int PW    = NL * LW;
    localparam int SQW   = 2 * MW;
    localparam int ACW   = 2 * PW;
    localparam int LIW   = (NL > 1) ? $clog2(NL) : 1;
    localparam int SHW   = (NL > 1) ? $clog2(2 * NL - 1) : 1;
    localparam logic [SQW:0] ESC_LIMIT = (SQW + 1)'(1) << (2 * FRAC_BITS + 2);

    // Control registers.
    mbe_pkg::state_t            state_reg, state_next;
    logic                       out_vld_reg, out_vld_next;
    logic [mbe_pkg::ITER_W-1:0] max_iter_reg, max_iter_next;
    logic [LIW-1:0]             li_reg, li_next;
    logic [LIW-1:0]             lj_reg, lj_next;
    logic                       pp_vld_reg, pp_vld_next;
    logic                       pp_last_reg, pp_last_next;
    logic                       issue_done_reg, issue_done_next;
    logic [ACW-1:0]             acc_reg, acc_next;

    // Payload registers.
    logic signed [mbe_pkg::COORD_W-1:0] c_re_reg, c_re_next;
    logic signed [mbe_pkg::COORD_W-1:0] c_im_reg, c_im_next;
    logic [MW-1:0]                      xm_reg, xm_next;
    logic [MW-1:0]                      ym_reg, ym_next;
    logic                               neg_reg, neg_next;
    logic [SQW-1:0]                     sqx_reg, sqx_next;
    logic [SQW-1:0]                     sqy_reg, sqy_next;
    logic [SQW-1:0]                     prod_reg, prod_next;
    logic signed [ZW-1:0]               nx_reg, nx_next;
    logic signed [ZW-1:0]               ny_reg, ny_next;
    logic [2*LW-1:0]                    pp_reg, pp_next;
    logic [SHW-1:0]                     pp_sh_reg, pp_sh_next;
    logic [COUNT_WIDTH-1:0]             count_reg, count_next;
    logic [mbe_pkg::BRIGHT_W-1:0]       bright_reg, bright_next;
    logic                               res_set_reg, res_set_next;
    logic                               out_set_reg, out_set_next;
    logic [mbe_pkg::BRIGHT_W-1:0]       out_bright_reg, out_bright_next;

    // Decoded control.
    logic                   accept;
    logic                   mul_active;
    logic                   busy;
    logic                   out_load;
    logic                   issue;
    logic                   last_slice;
    logic                   escape;
    logic                   last_iter;
    logic [COUNT_WIDTH-1:0] limit;
    logic [COUNT_WIDTH-1:0] count_inc;

    // Datapath intermediates.
    logic [MW-1:0]          op_a;
    logic [MW-1:0]          op_b;
    logic [PW-1:0]          op_a_pad;
    logic [PW-1:0]          op_b_pad;
    logic [ACW-1:0]         acc_sum;
    logic signed [SQW:0]    re_diff;
    logic signed [SQW:0]    re_shift;
    logic signed [SQW+1:0]  im_prod;
    logic signed [SQW+1:0]  im_shift;
    logic [SQW:0]           mag_sum;

    assign limit     = COUNT_WIDTH'(max_iter_reg);
    assign count_inc = count_reg + 1'b1;
    assign mag_sum   = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign escape    = mag_sum > ESC_LIMIT;
    assign last_iter = (count_inc == limit);
    assign last_slice = (li_reg == LIW'(NL - 1)) && (lj_reg == LIW'(NL - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbe_pkg::S_IDLE:
            begin
                if (point.valid)
                begin
                    state_next = (limit == '0) ? mbe_pkg::S_DONE : mbe_pkg::S_MUL_XY;
                end
            end
            mbe_pkg::S_MUL_XY:
            begin
                if (pp_last_reg)
                begin
                    state_next = mbe_pkg::S_UPDATE;
                end
            end
            mbe_pkg::S_UPDATE:
            begin
                state_next = mbe_pkg::S_MAGN;
            end
            mbe_pkg::S_MAGN:
            begin
                state_next = mbe_pkg::S_MUL_XX;
            end
            mbe_pkg::S_MUL_XX:
            begin
                if (pp_last_reg)
                begin
                    state_next = mbe_pkg::S_MUL_YY;
                end
            end
            mbe_pkg::S_MUL_YY:
            begin
                if (pp_last_reg)
                begin
                    state_next = mbe_pkg::S_TEST;
                end
            end
            mbe_pkg::S_TEST:
            begin
                state_next = (escape || last_iter) ? mbe_pkg::S_DONE : mbe_pkg::S_MUL_XY;
            end
            mbe_pkg::S_DONE:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    state_next = mbe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mbe_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        point.ready = 1'b0;
        mul_active  = 1'b0;
        busy        = 1'b1;
        out_load    = 1'b0;
        op_a        = xm_reg;
        op_b        = ym_reg;
        case (state_reg)
            mbe_pkg::S_IDLE:
            begin
                point.ready = 1'b1;
                busy        = 1'b0;
            end
            mbe_pkg::S_MUL_XY:
            begin
                mul_active = 1'b1;
            end
            mbe_pkg::S_MUL_XX:
            begin
                mul_active = 1'b1;
                op_b       = xm_reg;
            end
            mbe_pkg::S_MUL_YY:
            begin
                mul_active = 1'b1;
                op_a       = ym_reg;
            end
            mbe_pkg::S_DONE:
            begin
                busy     = 1'b0;
                out_load = !out_vld_reg || result.ready;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign accept = point.valid && point.ready;
    assign issue  = mul_active && !issue_done_reg;

    // Shared multiplier: a slice product per cycle when issuing, added next cycle.
    assign op_a_pad = PW'(op_a);
    assign op_b_pad = PW'(op_b);
    assign acc_sum  = acc_reg + (pp_vld_reg ? (ACW'(pp_reg) << (LW * pp_sh_reg)) : '0);

    always_comb
    begin
        pp_next         = op_a_pad[li_reg*LW +: LW] * op_b_pad[lj_reg*LW +: LW];
        pp_sh_next      = SHW'(li_reg) + SHW'(lj_reg);
        pp_vld_next     = issue;
        pp_last_next    = issue && last_slice;
        li_next         = li_reg;
        lj_next         = lj_reg;
        issue_done_next = issue_done_reg;
        acc_next        = acc_sum;
        if (issue)
        begin
            if (li_reg == LIW'(NL - 1))
            begin
                li_next = '0;
                lj_next = lj_reg + 1'b1;
            end
            else
            begin
                li_next = li_reg + 1'b1;
            end
            if (last_slice)
            begin
                issue_done_next = 1'b1;
                lj_next         = '0;
            end
        end
        if (pp_last_reg)
        begin
            acc_next        = '0;
            issue_done_next = 1'b0;
        end
    end

    // New z: floor-shifted real and imaginary parts plus c.
    assign re_diff  = {1'b0, sqx_reg} - {1'b0, sqy_reg};
    assign re_shift = re_diff >>> FRAC_BITS;
    assign im_prod  = neg_reg ? -$signed({1'b0, prod_reg, 1'b0}) : $signed({1'b0, prod_reg, 1'b0});
    assign im_shift = im_prod >>> FRAC_BITS;

    // Iteration datapath.
    always_comb
    begin
        c_re_next       = c_re_reg;
        c_im_next       = c_im_reg;
        xm_next         = xm_reg;
        ym_next         = ym_reg;
        neg_next        = neg_reg;
        sqx_next        = sqx_reg;
        sqy_next        = sqy_reg;
        prod_next       = prod_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        count_next      = count_reg;
        bright_next     = bright_reg;
        res_set_next    = res_set_reg;
        out_set_next    = out_set_reg;
        out_bright_next = out_bright_reg;

        // A new point starts from z = 0.
        if (accept)
        begin
            c_re_next    = point.c_real;
            c_im_next    = point.c_imag;
            xm_next      = '0;
            ym_next      = '0;
            neg_next     = 1'b0;
            sqx_next     = '0;
            sqy_next     = '0;
            count_next   = '0;
            bright_next  = '0;
            res_set_next = 1'b1;
        end

        // Finished products land in their destination.
        if (pp_last_reg)
        begin
            case (state_reg)
                mbe_pkg::S_MUL_XY: prod_next = acc_sum[SQW-1:0];
                mbe_pkg::S_MUL_XX: sqx_next  = acc_sum[SQW-1:0];
                mbe_pkg::S_MUL_YY: sqy_next  = acc_sum[SQW-1:0];
                default:           prod_next = prod_reg;
            endcase
        end

        if (state_reg == mbe_pkg::S_UPDATE)
        begin
            nx_next = re_shift[ZW-1:0] + ZW'(c_re_reg);
            ny_next = im_shift[ZW-1:0] + ZW'(c_im_reg);
        end

        if (state_reg == mbe_pkg::S_MAGN)
        begin
            xm_next  = nx_reg[ZW-1] ? MW'(-nx_reg) : MW'(nx_reg);
            ym_next  = ny_reg[ZW-1] ? MW'(-ny_reg) : MW'(ny_reg);
            neg_next = nx_reg[ZW-1] ^ ny_reg[ZW-1];
        end

        // Count the iteration and check for escape.
        if (state_reg == mbe_pkg::S_TEST)
        begin
            count_next = count_inc;
            if (bright_reg != mbe_pkg::BRIGHT_MAX)
            begin
                bright_next = bright_reg + 1'b1;
            end
            res_set_next = !escape;
        end

        if (out_load)
        begin
            out_set_next    = res_set_reg;
            out_bright_next = bright_reg;
        end
    end

    // Output handshake and configuration.
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        max_iter_next = max_iter_reg;
        if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        if (cfg.valid)
        begin
            max_iter_next = cfg.max_iterations;
        end
    end

    assign cfg.ready         = 1'b1;
    assign result.valid      = out_vld_reg;
    assign result.in_set     = out_set_reg;
    assign result.brightness = out_bright_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mbe_pkg::S_IDLE;
            out_vld_reg    <= 1'b0;
            max_iter_reg   <= mbe_pkg::MAX_ITER_RESET;
            li_reg         <= '0;
            lj_reg         <= '0;
            pp_vld_reg     <= 1'b0;
            pp_last_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_vld_reg    <= out_vld_next;
            max_iter_reg   <= max_iter_next;
            li_reg         <= li_next;
            lj_reg         <= lj_next;
            pp_vld_reg     <= pp_vld_next;
            pp_last_reg    <= pp_last_next;
            issue_done_reg <= issue_done_next;
            acc_reg        <= acc_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        c_re_reg       <= c_re_next;
        c_im_reg       <= c_im_next;
        xm_reg         <= xm_next;
        ym_reg         <= ym_next;
        neg_reg        <= neg_next;
        sqx_reg        <= sqx_next;
        sqy_reg        <= sqy_next;
        prod_reg       <= prod_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        pp_reg         <= pp_next;
        pp_sh_reg      <= pp_sh_next;
        count_reg      <= count_next;
        bright_reg     <= bright_next;
        res_set_reg    <= res_set_next;
        out_set_reg    <= out_set_next;
        out_bright_reg <= out_bright_next;
    end

    // Checks on the sequencer and the shared multiplier.
    `ASSERT_IMPLIES(a_count_below_limit, clk, rst_n, busy, count_reg < limit)
    `ASSERT_IMPLIES(a_bright_tracks_count, clk, rst_n, busy && (count_reg < COUNT_WIDTH'(mbe_pkg::BRIGHT_MAX)), bright_reg == mbe_pkg::BRIGHT_W'(count_reg))
    `ASSERT_IMPLIES(a_acc_clear_at_square, clk, rst_n, (state_reg == mbe_pkg::S_MUL_XX) && ($past(state_reg) != mbe_pkg::S_MUL_XX), acc_reg == '0)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !point.ready)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Mandelbrot escape-time block.
module tb_top;

    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int HOLD_CYCLES = 500;

    // Escape bound 4.0 at the scale of a squared magnitude.
    localparam logic signed [127:0] ESCAPE_BOUND = 128'sd1 <<< (2 * FRAC_BITS + 2);

    // Handy points in Q4.28.
    localparam logic signed [mbe_pkg::COORD_W-1:0] Q_ONE   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [mbe_pkg::COORD_W-1:0] Q_TWO   = 32'sd2 <<< FRAC_BITS;
    localparam logic signed [mbe_pkg::COORD_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [mbe_pkg::COORD_W-1:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] Q_ZERO  = 32'sd0;

    typedef struct packed {
        logic                         in_set;
        logic [mbe_pkg::BRIGHT_W-1:0] brightness;
    } escape_t;

    logic clk;
    logic rst_n;

    mbe_in_if  point_if ();
    mbe_out_if result_if ();
    mbe_cfg_if cfg_if ();

    mandelbrot_escape_time #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Expected escape results, oldest first, and the limit the predictor uses.
    escape_t                    expected_escapes[$];
    logic [mbe_pkg::ITER_W-1:0] iter_limit = mbe_pkg::MAX_ITER_RESET;
    int                         failures   = 0;
    int unsigned                burst_left = 0;
    bit                         hold_off   = 1'b0;

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Escape-time predictor: exact fixed-point iteration of z = z*z + c.
    function automatic escape_t escape_time(input logic signed [mbe_pkg::COORD_W-1:0] cr,
                                            input logic signed [mbe_pkg::COORD_W-1:0] ci,
                                            input logic [mbe_pkg::ITER_W-1:0] limit);
        logic signed [63:0]  x;
        logic signed [63:0]  y;
        logic signed [63:0]  cr_w;
        logic signed [63:0]  ci_w;
        logic signed [127:0] xw;
        logic signed [127:0] yw;
        logic signed [127:0] re_sq;
        logic signed [127:0] im_sq;
        escape_t             res;
        int unsigned         n;
        cr_w = cr;
        ci_w = ci;
        x = 64'sd0;
        y = 64'sd0;
        res.in_set = 1'b1;
        res.brightness = '0;
        for (n = 0; n < limit; n++)
        begin
            xw = x;
            yw = y;
            // Both shifts are arithmetic, so they round toward minus infinity.
            re_sq = (xw * xw - yw * yw) >>> FRAC_BITS;
            im_sq = (xw * yw * 128'sd2) >>> FRAC_BITS;
            x = re_sq[63:0] + cr_w;
            y = im_sq[63:0] + ci_w;
            if (res.brightness != mbe_pkg::BRIGHT_MAX)
                res.brightness = res.brightness + 1'b1;
            xw = x;
            yw = y;
            if (xw * xw + yw * yw > ESCAPE_BOUND)
            begin
                res.in_set = 1'b0;
                break;
            end
        end
        return res;
    endfunction

    // Offer one point in bursts with random gaps, and predict its result on acceptance.
    task automatic send_point(input logic signed [mbe_pkg::COORD_W-1:0] cr,
                              input logic signed [mbe_pkg::COORD_W-1:0] ci);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                point_if.valid = 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        @(negedge clk);
        point_if.valid  = 1'b1;
        point_if.c_real = cr;
        point_if.c_imag = ci;
        do
            @(posedge clk);
        while (!point_if.ready);
        expected_escapes.push_back(escape_time(cr, ci, iter_limit));
        burst_left--;
    endtask

    // Random point: full range, the edge of the main cardioid, or the set's window.
    task automatic send_random_point();
        logic signed [mbe_pkg::COORD_W-1:0] cr;
        logic signed [mbe_pkg::COORD_W-1:0] ci;
        case ($urandom_range(0, 3))
            0:
            begin
                cr = $urandom;
                ci = $urandom;
            end
            1:
            begin
                cr = $urandom_range(0, 32'h0100_0000) + 32'h0400_0000;
                ci = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end
            default:
            begin
                cr = $urandom_range(0, 32'h3000_0000) - 32'h2400_0000;
                ci = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
            end
        endcase
        send_point(cr, ci);
    endtask

    // Stop offering points and wait until every expected result has come back.
    task automatic wait_idle();
        @(negedge clk);
        point_if.valid = 1'b0;
        while (expected_escapes.size() != 0)
            @(negedge clk);
    endtask

    // Write the iteration limit; only called while the block is idle.
    task automatic set_iter_limit(input logic [mbe_pkg::ITER_W-1:0] limit);
        @(negedge clk);
        cfg_if.valid          = 1'b1;
        cfg_if.max_iterations = limit;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        iter_limit = limit;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Limit left at its reset value: a point in the set and the field extremes.
    task automatic test_reset_limit();
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MIN, Q_MAX);
        send_point(Q_MAX, Q_MIN);
        wait_idle();
    endtask

    // A limit of zero runs no iteration at all.
    task automatic test_zero_limit();
        set_iter_limit('0);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_MAX, Q_MIN);
        send_random_point();
        wait_idle();
    endtask

    // A single iteration: a magnitude of exactly two stays, one step beyond escapes.
    task automatic test_single_iteration();
        set_iter_limit(16'd1);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_TWO + Q_ONE, Q_ZERO);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_TWO + 32'sd1, Q_ZERO);
        wait_idle();
    endtask

    // Brightness saturation and points that cycle on the boundary of the set.
    task automatic test_saturation();
        set_iter_limit(16'd300);
        send_point(Q_ZERO, Q_ZERO);
        send_point(-Q_TWO, Q_ZERO);
        send_point(-Q_ONE, Q_ZERO);
        send_point(Q_ZERO, Q_ONE);
        send_point(32'sh0410_0000, Q_ZERO);
        wait_idle();
    endtask

    // Random points over a spread of iteration limits.
    task automatic test_random_points();
        int unsigned                round_idx;
        int unsigned                k;
        logic [mbe_pkg::ITER_W-1:0] limit;
        for (round_idx = 0; round_idx < 6; round_idx++)
        begin
            case (round_idx % 3)
                0:       limit = $urandom_range(1, 40);
                1:       limit = $urandom_range(41, 256);
                default: limit = $urandom_range(2, 12);
            endcase
            set_iter_limit(limit);
            for (k = 0; k < 16; k++)
                send_random_point();
            wait_idle();
        end
    endtask

    // Result side held off for a long stretch while points keep coming.
    task automatic test_backpressure();
        int unsigned k;
        set_iter_limit(16'd3);
        hold_off = 1'b1;
        for (k = 0; k < 8; k++)
            send_random_point();
        wait_idle();
    endtask

    // Largest limit: one point that never escapes and two that do.
    task automatic test_full_limit();
        set_iter_limit(16'hFFFF);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_TWO + Q_ONE / 2, Q_ZERO);
        send_point(32'sh0420_0000, 32'sh0010_0000);
        wait_idle();
    endtask

    // Result side: runs of always-ready, random-ready and short stalls, or a long hold.
    initial
    begin : result_sink
        int unsigned seg;
        int unsigned mode;
        result_if.ready = 1'b0;
        forever
        begin
            if (hold_off)
            begin
                @(negedge clk);
                result_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                seg  = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(1, 40);
                while (seg != 0 && !hold_off)
                begin
                    @(negedge clk);
                    case (mode)
                        0:       result_if.ready = 1'b1;
                        1:       result_if.ready = $urandom_range(0, 1);
                        default: result_if.ready = 1'b0;
                    endcase
                    seg--;
                end
            end
        end
    end

    // Compare each accepted result item with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        escape_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_escapes.size() == 0)
            begin
                $error("unexpected result item: in_set=%0d brightness=%0d",
                       result_if.in_set, result_if.brightness);
                failures++;
            end
            else
            begin
                want = expected_escapes.pop_front();
                if (result_if.in_set !== want.in_set)
                begin
                    $error("in_set: expected %0d, actual %0d", want.in_set, result_if.in_set);
                    failures++;
                end
                if (result_if.brightness !== want.brightness)
                begin
                    $error("brightness: expected %0d, actual %0d",
                           want.brightness, result_if.brightness);
                    failures++;
                end
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #50_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Reset, then the tests in turn.
    initial
    begin
        rst_n                 = 1'b0;
        point_if.valid        = 1'b0;
        point_if.c_real       = '0;
        point_if.c_imag       = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.max_iterations = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_limit();
        test_zero_limit();
        test_single_iteration();
        test_saturation();
        test_random_points();
        test_backpressure();
        test_full_limit();

        wait_idle();
        repeat (20) @(negedge clk);
        if (failures == 0 && expected_escapes.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
